@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of the project.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NSQM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define NSQM_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/nsqm_pkg.sv @@
// Package for the named stack/queue manager: sequencer state type,
// command and status codes. Depends on nothing.
`default_nettype none

package nsqm_pkg;

   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;

   localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EXISTS  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MISSING = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_LOOK  = 5'b00010,
      S_ALLOC = 5'b00100,
      S_LINK2 = 5'b01000,
      S_POP   = 5'b10000
   } state_type;

endpackage

`default_nettype wire

@@ rtl/named_stack_queue_manager_top.sv @@
// Named stack/queue manager: lists sharing one linked node pool.
// Depends on nsqm_pkg.
//
// Usage:
//   Commands enter on the req_ ports. An item is taken at a rising edge
//   where start is high and busy is low; busy stays high while the item
//   is worked on. Every item gives exactly one result on the rsp_ ports,
//   marked by rsp_valid for a single cycle; the receiver cannot stall it.
//   Create places a stack or queue at list_id, push adds a value (stack at
//   the head, queue at the tail), pop removes the head and returns it.
// Sequence (the result shows in the first cycle a new item can be taken):
//   create, errors, unused code : S_LOOK
//   push to empty list or stack : S_LOOK, S_ALLOC
//   push to non-empty queue     : S_LOOK, S_ALLOC, S_LINK2 (tail link, then
//                                 new node link)
//   pop                         : S_LOOK, S_POP
//   The steps are set by the single write port of the node link memory and
//   the registered reads of the head/tail and node memories, walked by the
//   sequencer one dependent access per cycle.
// Reset: all lists absent, pool all free. Free nodes are handed out from the
//   chain of recycled nodes first and then from a fill counter, so no
//   clearing pass runs and the block takes items right after reset.
`default_nettype none

module named_stack_queue_manager_top
   import nsqm_pkg::*;
#(
   parameter int NUM_LISTS   = 16,
   parameter int POOL_NODES  = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [CMD_W-1:0]    req_cmd,
   input  wire logic [3:0]          req_list_id,
   input  wire logic                req_list_kind,
   input  wire logic signed [31:0]  req_push_value,
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic signed [31:0]       rsp_pop_value
);

   localparam int LIST_W = ($clog2(NUM_LISTS) > 0) ? $clog2(NUM_LISTS) : 1;
   localparam int NODE_W = $clog2(POOL_NODES);
   localparam int CNT_W  = $clog2(POOL_NODES + 1);

   // sequencer and captured item
   state_type                state_ff, state_in;
   logic [CMD_W-1:0]         cmd_ff;
   logic [3:0]               id_ff;
   logic                     kind_ff;
   logic [VALUE_WIDTH-1:0]   val_ff;
   logic [NODE_W-1:0]        node_ff, node_in;
   logic                     from_recycled_ff, from_recycled_in;

   // per-list flags
   logic [NUM_LISTS-1:0]     list_valid_ff, list_valid_in;
   logic [NUM_LISTS-1:0]     list_queue_ff, list_queue_in;
   logic [NUM_LISTS-1:0]     list_empty_ff, list_empty_in;

   // free pool bookkeeping
   logic [NODE_W-1:0]        recycled_head_ff, recycled_head_in;
   logic [CNT_W-1:0]         recycled_count_ff, recycled_count_in;
   logic [CNT_W-1:0]         next_fresh_ff, next_fresh_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic signed [31:0]       rsp_pop_value_ff, rsp_pop_value_in;

   // memories
   logic [NODE_W-1:0]        head_mem [NUM_LISTS];
   logic [NODE_W-1:0]        tail_mem [NUM_LISTS];
   logic [NODE_W-1:0]        link_mem [POOL_NODES];
   logic [VALUE_WIDTH-1:0]   value_mem [POOL_NODES];
   logic [NODE_W-1:0]        head_rd_ff, tail_rd_ff, link_rd_ff;
   logic [VALUE_WIDTH-1:0]   value_rd_ff;

   logic                     head_we, tail_we, link_we, value_we;
   logic [NODE_W-1:0]        head_wdata, tail_wdata;
   logic [NODE_W-1:0]        link_waddr, link_wdata, node_raddr;

   logic                     accept;
   logic [LIST_W-1:0]        li, req_li;
   logic                     in_range, present, pool_full;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign li        = LIST_W'(id_ff);
   assign req_li    = LIST_W'(req_list_id);
   assign in_range  = (int'(id_ff) < NUM_LISTS);
   assign present   = in_range && list_valid_ff[li];
   assign pool_full = (next_fresh_ff == CNT_W'(POOL_NODES)) && (recycled_count_ff == '0);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_pop_value = rsp_pop_value_ff;

   // Sequencer: one dependent memory access per state.
   always_comb begin
      state_in          = state_ff;
      node_in           = node_ff;
      from_recycled_in  = from_recycled_ff;
      list_valid_in     = list_valid_ff;
      list_queue_in     = list_queue_ff;
      list_empty_in     = list_empty_ff;
      recycled_head_in  = recycled_head_ff;
      recycled_count_in = recycled_count_ff;
      next_fresh_in     = next_fresh_ff;
      rsp_valid_in      = 1'b0;
      rsp_status_in     = ST_OK;
      rsp_pop_value_in  = '0;
      head_we           = 1'b0;
      tail_we           = 1'b0;
      link_we           = 1'b0;
      value_we          = 1'b0;
      head_wdata        = node_ff;
      tail_wdata        = node_ff;
      link_waddr        = node_ff;
      link_wdata        = node_ff;
      node_raddr        = recycled_head_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_LOOK;
            end
         end

         S_LOOK: begin
            case (cmd_ff)
               CMD_CREATE: begin
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
                  if (!in_range) begin
                     rsp_status_in = ST_MISSING;
                  end else if (list_valid_ff[li]) begin
                     rsp_status_in = ST_EXISTS;
                  end else begin
                     list_valid_in[li] = 1'b1;
                     list_queue_in[li] = kind_ff;
                     list_empty_in[li] = 1'b1;
                  end
               end
               CMD_PUSH: begin
                  if (!present) begin
                     state_in      = S_IDLE;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_MISSING;
                  end else if (pool_full) begin
                     state_in      = S_IDLE;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_FULL;
                  end else begin
                     // take a recycled node first, else a never-used one
                     state_in = S_ALLOC;
                     if (recycled_count_ff != '0) begin
                        node_in           = recycled_head_ff;
                        from_recycled_in  = 1'b1;
                        recycled_count_in = recycled_count_ff - CNT_W'(1);
                     end else begin
                        node_in          = next_fresh_ff[NODE_W-1:0];
                        from_recycled_in = 1'b0;
                        next_fresh_in    = next_fresh_ff + CNT_W'(1);
                     end
                  end
               end
               CMD_POP: begin
                  if (!present) begin
                     state_in      = S_IDLE;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_MISSING;
                  end else if (list_empty_ff[li]) begin
                     state_in      = S_IDLE;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_EMPTY;
                  end else begin
                     node_raddr = head_rd_ff;
                     state_in   = S_POP;
                  end
               end
               default: begin
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
               end
            endcase
         end

         S_ALLOC: begin
            value_we = 1'b1;
            if (from_recycled_ff) begin
               recycled_head_in = link_rd_ff;
            end
            if (list_empty_ff[li]) begin
               // first node: links to itself, head and tail both point at it
               link_we           = 1'b1;
               head_we           = 1'b1;
               tail_we           = 1'b1;
               list_empty_in[li] = 1'b0;
               state_in          = S_IDLE;
               rsp_valid_in      = 1'b1;
            end else if (list_queue_ff[li]) begin
               link_we    = 1'b1;
               link_waddr = tail_rd_ff;
               tail_we    = 1'b1;
               state_in   = S_LINK2;
            end else begin
               link_we      = 1'b1;
               link_wdata   = head_rd_ff;
               head_we      = 1'b1;
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end

         S_LINK2: begin
            // new queue tail links to itself
            link_we      = 1'b1;
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end

         S_POP: begin
            rsp_pop_value_in = 32'($signed(value_rd_ff));
            state_in         = S_IDLE;
            rsp_valid_in     = 1'b1;
            if (list_queue_ff[li] && (head_rd_ff == tail_rd_ff)) begin
               list_empty_in[li] = 1'b1;
            end else if (!list_queue_ff[li] && (link_rd_ff == head_rd_ff)) begin
               list_empty_in[li] = 1'b1;
            end else begin
               head_we    = 1'b1;
               head_wdata = link_rd_ff;
            end
            // return the node to the recycled chain
            link_we           = 1'b1;
            link_waddr        = head_rd_ff;
            link_wdata        = recycled_head_ff;
            recycled_head_in  = head_rd_ff;
            recycled_count_in = recycled_count_ff + CNT_W'(1);
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         list_valid_ff     <= '0;
         list_queue_ff     <= '0;
         list_empty_ff     <= '1;
         recycled_count_ff <= '0;
         next_fresh_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         list_valid_ff     <= list_valid_in;
         list_queue_ff     <= list_queue_in;
         list_empty_ff     <= list_empty_in;
         recycled_count_ff <= recycled_count_in;
         next_fresh_ff     <= next_fresh_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_cmd;
         id_ff   <= req_list_id;
         kind_ff <= req_list_kind;
         val_ff  <= VALUE_WIDTH'($unsigned(req_push_value));
      end
      node_ff          <= node_in;
      from_recycled_ff <= from_recycled_in;
      recycled_head_ff <= recycled_head_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_pop_value_ff <= rsp_pop_value_in;
   end

   // List head and tail memories: read at the item's list when it is taken.
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[li] <= head_wdata;
      end
      if (tail_we) begin
         tail_mem[li] <= tail_wdata;
      end
      if (accept) begin
         head_rd_ff <= head_mem[req_li];
         tail_rd_ff <= tail_mem[req_li];
      end
   end

   // Node link and value memories: one write, one registered read each.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (value_we) begin
         value_mem[node_ff] <= val_ff;
      end
      link_rd_ff  <= link_mem[node_raddr];
      value_rd_ff <= value_mem[node_raddr];
   end

endmodule

`default_nettype wire

@@ rtl/nsqm_checker.sv @@
// Port-level checker for the named stack/queue manager, bound to the top.
// Depends on nsqm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nsqm_checker
   import nsqm_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire logic                rsp_valid,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic signed [31:0]  rsp_pop_value
);

   logic accept;
   assign accept = start && !busy;

   `NSQM_ASSERT_NXT(a_busy_after_accept, accept, busy, "busy not raised after item")
   `NSQM_ASSERT_NXT(a_no_early_rsp, accept, !rsp_valid, "result one cycle after item")
   `NSQM_ASSERT_IMP(a_rsp_when_idle, rsp_valid, !busy && $past(busy), "result while busy")
   `NSQM_ASSERT_IMP(a_status_code, rsp_valid, rsp_status <= ST_FULL, "bad status code")
   `NSQM_ASSERT_IMP(a_zero_on_fail, rsp_valid && (rsp_status != ST_OK), rsp_pop_value == 0, "value on failure")

endmodule

bind named_stack_queue_manager_top nsqm_checker u_nsqm_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_status    (rsp_status),
   .rsp_pop_value (rsp_pop_value)
);

`default_nettype wire
